@@ hw/rtl/gha_pkg.sv @@
package gha_pkg;

  localparam int unsigned SLOT_COUNT_DEF   = 1024;
  localparam int unsigned VERSION_BITS_DEF = 16;

  localparam logic [1:0] MODE_CREATE  = 2'd0;
  localparam logic [1:0] MODE_DESTROY = 2'd1;
  localparam logic [1:0] MODE_QUERY   = 2'd2;
  localparam logic [1:0] MODE_FIND    = 2'd3;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_NOTFOUND = 2'd1;
  localparam logic [1:0] STATUS_FULL     = 2'd2;

endpackage

@@ hw/rtl/generational_handle_allocator_unit.sv @@
// Channel  Direction  Handshake                  Payload
// in       input      in_valid_i / in_ready_o    mode_i, slot_index_i, handle_version_i
// out      output     out_valid_o / out_ready_i  out_index_o, out_version_o, alive_o, status_o
//
// Create, destroy and query accept with a slot table read, then an update cycle that
// loads the result register and writes the table on a successful create or destroy.
// Find-next reads the start slot on accept, then checks slots in turn (at least one);
// the single read port of the slot table checks one slot per cycle.
// No clearing after reset: unwritten slots sit at or above the used count or are slot 0.
// out_ready_i low stalls the update cycle; a new item is taken while a result waits.
module generational_handle_allocator_unit #(
  parameter int unsigned SLOT_COUNT   = gha_pkg::SLOT_COUNT_DEF,
  parameter int unsigned VERSION_BITS = gha_pkg::VERSION_BITS_DEF,
  localparam int unsigned IW = $clog2(SLOT_COUNT),
  localparam int unsigned VB = VERSION_BITS
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [1:0]    mode_i,
  input  logic [IW-1:0] slot_index_i,
  input  logic [VB-1:0] handle_version_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [IW:0]   out_index_o,
  output logic [VB-1:0] out_version_o,
  output logic          alive_o,
  output logic [1:0]    status_o
);

  localparam logic [0:0] ST_IDLE = 1'b0;
  localparam logic [0:0] ST_OP   = 1'b1;
  localparam logic [IW:0] SlotEnd = (IW+1)'(SLOT_COUNT);
  localparam int unsigned RW = IW + VB;

  logic [0:0]    state_q, state_d;
  logic [1:0]    mode_q, mode_d;
  logic [IW-1:0] idx_q, idx_d;
  logic [VB-1:0] ver_q, ver_d;
  logic [IW:0]   scan_q, scan_d;
  logic [IW:0]   slots_used_q, slots_used_d;
  logic [IW-1:0] free_head_q, free_head_d;
  logic [IW:0]   free_count_q, free_count_d;

  logic          out_valid_q, out_valid_d;
  logic [IW:0]   out_index_q, out_index_d;
  logic [VB-1:0] out_version_q, out_version_d;
  logic          alive_q, alive_d;
  logic [1:0]    status_q, status_d;

  logic          ram_we, ram_re;
  logic [IW-1:0] ram_waddr, ram_raddr;
  logic [RW-1:0] ram_wdata, ram_rdata;
  logic [IW-1:0] rd_link;
  logic [VB-1:0] rd_ver;

  logic          accept, out_free, handle_live, scan_live, pop_ok;
  logic [IW:0]   scan_next;

  gha_ram #(
    .WIDTH(RW),
    .DEPTH(SLOT_COUNT)
  ) u_slots (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign rd_link = ram_rdata[RW-1:VB];
  assign rd_ver  = ram_rdata[VB-1:0];

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign scan_next  = scan_q + 1'b1;

  assign handle_live = (idx_q != '0) && ({1'b0, idx_q} < slots_used_q) &&
                       (rd_link == idx_q) && (rd_ver == ver_q);
  assign scan_live   = (scan_q != '0) && (scan_q < slots_used_q) &&
                       (rd_link == scan_q[IW-1:0]);
  assign pop_ok      = (free_count_q != '0) && ({1'b0, free_head_q} < slots_used_q);

  always_comb begin
    state_d       = state_q;
    mode_d        = mode_q;
    idx_d         = idx_q;
    ver_d         = ver_q;
    scan_d        = scan_q;
    slots_used_d  = slots_used_q;
    free_head_d   = free_head_q;
    free_count_d  = free_count_q;
    out_valid_d   = out_valid_q && !out_ready_i;
    out_index_d   = out_index_q;
    out_version_d = out_version_q;
    alive_d       = alive_q;
    status_d      = status_q;
    ram_we        = 1'b0;
    ram_waddr     = idx_q;
    ram_wdata     = '0;
    ram_re        = 1'b0;
    ram_raddr     = slot_index_i;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          mode_d    = mode_i;
          idx_d     = slot_index_i;
          ver_d     = handle_version_i;
          scan_d    = {1'b0, slot_index_i};
          ram_re    = 1'b1;
          ram_raddr = (mode_i == gha_pkg::MODE_CREATE) ? free_head_q : slot_index_i;
          state_d   = ST_OP;
        end
      end
      ST_OP: begin
        if (mode_q == gha_pkg::MODE_FIND && !scan_live && scan_next < slots_used_q) begin
          // advance to the next slot
          scan_d    = scan_next;
          ram_re    = 1'b1;
          ram_raddr = scan_next[IW-1:0];
        end else if (out_free) begin
          state_d     = ST_IDLE;
          out_valid_d = 1'b1;
          unique case (mode_q)
            gha_pkg::MODE_CREATE: begin
              if (pop_ok) begin
                ram_we        = 1'b1;
                ram_waddr     = free_head_q;
                ram_wdata     = {free_head_q, rd_ver};
                free_head_d   = rd_link;
                free_count_d  = free_count_q - 1'b1;
                out_index_d   = {1'b0, free_head_q};
                out_version_d = rd_ver;
                alive_d       = 1'b1;
                status_d      = gha_pkg::STATUS_OK;
              end else if (slots_used_q < SlotEnd) begin
                ram_we        = 1'b1;
                ram_waddr     = slots_used_q[IW-1:0];
                ram_wdata     = {slots_used_q[IW-1:0], {VB{1'b0}}};
                slots_used_d  = slots_used_q + 1'b1;
                out_index_d   = slots_used_q;
                out_version_d = '0;
                alive_d       = 1'b1;
                status_d      = gha_pkg::STATUS_OK;
              end else begin
                out_index_d   = SlotEnd;
                out_version_d = '0;
                alive_d       = 1'b0;
                status_d      = gha_pkg::STATUS_FULL;
              end
            end
            gha_pkg::MODE_DESTROY: begin
              out_index_d = {1'b0, idx_q};
              alive_d     = 1'b0;
              if (handle_live) begin
                ram_we        = 1'b1;
                ram_waddr     = idx_q;
                ram_wdata     = {free_head_q, rd_ver + 1'b1};
                free_head_d   = idx_q;
                free_count_d  = free_count_q + 1'b1;
                out_version_d = rd_ver + 1'b1;
                status_d      = gha_pkg::STATUS_OK;
              end else begin
                out_version_d = '0;
                status_d      = gha_pkg::STATUS_NOTFOUND;
              end
            end
            gha_pkg::MODE_QUERY: begin
              out_index_d   = {1'b0, idx_q};
              out_version_d = (idx_q != '0 && {1'b0, idx_q} < slots_used_q) ? rd_ver : '0;
              alive_d       = handle_live;
              status_d      = handle_live ? gha_pkg::STATUS_OK : gha_pkg::STATUS_NOTFOUND;
            end
            default: begin
              if (scan_live) begin
                out_index_d   = scan_q;
                out_version_d = rd_ver;
                alive_d       = 1'b1;
                status_d      = gha_pkg::STATUS_OK;
              end else begin
                out_index_d   = SlotEnd;
                out_version_d = '0;
                alive_d       = 1'b0;
                status_d      = gha_pkg::STATUS_NOTFOUND;
              end
            end
          endcase
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      slots_used_q <= (IW+1)'(1);
      free_head_q  <= '0;
      free_count_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      slots_used_q <= slots_used_d;
      free_head_q  <= free_head_d;
      free_count_q <= free_count_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q        <= mode_d;
    idx_q         <= idx_d;
    ver_q         <= ver_d;
    scan_q        <= scan_d;
    out_index_q   <= out_index_d;
    out_version_q <= out_version_d;
    alive_q       <= alive_d;
    status_q      <= status_d;
  end

  assign out_valid_o   = out_valid_q;
  assign out_index_o   = out_index_q;
  assign out_version_o = out_version_q;
  assign alive_o       = alive_q;
  assign status_o      = status_q;

`ifndef NO_ASSERTIONS
  a_free_below_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_count_q < slots_used_q)
    else $error("free list longer than used slots");

  a_used_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    slots_used_q != '0 && slots_used_q <= SlotEnd)
    else $error("used slot count out of range");

  a_full_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == gha_pkg::STATUS_FULL |-> slots_used_q == SlotEnd)
    else $error("full status with room left");

  a_no_write_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> !ram_we)
    else $error("table write during accept");

  a_result_ends_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_OP && state_d == ST_IDLE |=> out_valid_o)
    else $error("item finished without result");
`endif

endmodule

@@ hw/rtl/gha_ram.sv @@
module gha_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import gha_pkg::*;

  localparam int unsigned SLOTS = SLOT_COUNT_DEF;
  localparam int unsigned VW    = VERSION_BITS_DEF;
  localparam int unsigned IW    = $clog2(SLOTS);
  localparam int unsigned VMAX  = (1 << VW) - 1;

  typedef struct packed {
    logic [IW:0]   slot;
    logic [VW-1:0] ver;
    logic          live;
    logic [1:0]    st;
  } reply_t;

  class handle_table_sb;
    logic [IW-1:0] link_q [SLOTS];
    logic [VW-1:0] ver_q [SLOTS];
    int unsigned   used;
    int unsigned   head;
    int unsigned   nfree;
    reply_t        expected_q[$];
    int unsigned   n_ops [4];
    int unsigned   n_full;
    int unsigned   n_rejected;
    int unsigned   n_found;
    int unsigned   n_checked;
    int unsigned   mismatches;

    function new();
      for (int unsigned i = 0; i < SLOTS; i++) begin
        link_q[i] = '0;
        ver_q[i]  = '0;
      end
      used       = 1;
      head       = 0;
      nfree      = 0;
      n_full     = 0;
      n_rejected = 0;
      n_found    = 0;
      n_checked  = 0;
      mismatches = 0;
      for (int k = 0; k < 4; k++) n_ops[k] = 0;
    endfunction

    function bit is_live(int unsigned idx, logic [VW-1:0] v);
      if (idx == 0 || idx >= used) return 1'b0;
      return (link_q[idx] == idx) && (ver_q[idx] == v);
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    // Probe for a slot below the used count that is alive (or freed).
    function bit pick_slot(bit want_live, output int unsigned idx);
      idx = 0;
      if (used < 2) return 1'b0;
      for (int n = 0; n < 32; n++) begin
        idx = $urandom_range(1, used - 1);
        if ((link_q[idx] == idx) == want_live) return 1'b1;
      end
      return 1'b0;
    endfunction

    function void note_input(logic [1:0] mode, logic [IW-1:0] idx, logic [VW-1:0] v);
      reply_t      r;
      int unsigned i;
      r.slot = (IW + 1)'(SLOTS);
      r.ver  = '0;
      r.live = 1'b0;
      r.st   = STATUS_NOTFOUND;
      n_ops[mode]++;
      case (mode)
        MODE_CREATE: begin
          if (nfree != 0 && head < used) begin
            i         = head;
            head      = link_q[i];
            link_q[i] = IW'(i);
            nfree--;
            r.slot = (IW + 1)'(i);
            r.ver  = ver_q[i];
            r.live = 1'b1;
            r.st   = STATUS_OK;
          end else if (used < SLOTS) begin
            i         = used;
            link_q[i] = IW'(i);
            ver_q[i]  = '0;
            used++;
            r.slot = (IW + 1)'(i);
            r.live = 1'b1;
            r.st   = STATUS_OK;
          end else begin
            r.st = STATUS_FULL;
            n_full++;
          end
        end
        MODE_DESTROY: begin
          r.slot = {1'b0, idx};
          if (is_live(idx, v)) begin
            link_q[idx] = IW'(head);
            ver_q[idx]  = ver_q[idx] + 1'b1;
            head        = idx;
            nfree++;
            r.ver = ver_q[idx];
            r.st  = STATUS_OK;
          end else begin
            n_rejected++;
          end
        end
        MODE_QUERY: begin
          r.slot = {1'b0, idx};
          r.live = is_live(idx, v);
          r.ver  = (idx < used) ? ver_q[idx] : '0;
          r.st   = r.live ? STATUS_OK : STATUS_NOTFOUND;
        end
        default: begin
          for (i = idx; i < used && !r.live; i++) begin
            if (is_live(i, ver_q[i])) begin
              r.slot = (IW + 1)'(i);
              r.ver  = ver_q[i];
              r.live = 1'b1;
              r.st   = STATUS_OK;
              n_found++;
            end
          end
        end
      endcase
      expected_q.push_back(r);
    endfunction

    function void note_mismatch(string msg);
      mismatches++;
      if (mismatches <= 10) $display("MISMATCH %s", msg);
    endfunction

    function void check_result(logic [IW:0] slot, logic [VW-1:0] v, logic live, logic [1:0] st);
      reply_t want;
      n_checked++;
      if (expected_q.size() == 0) begin
        note_mismatch($sformatf("unexpected result: index %0d version %0d alive %0b status %0d",
                                slot, v, live, st));
        return;
      end
      want = expected_q.pop_front();
      if (slot !== want.slot || v !== want.ver || live !== want.live || st !== want.st)
        note_mismatch($sformatf({"result %0d: expected index %0d version %0d alive %0b ",
                                 "status %0d, got index %0d version %0d alive %0b status %0d"},
                                n_checked, want.slot, want.ver, want.live, want.st,
                                slot, v, live, st));
    endfunction
  endclass

  logic          clk_i = 1'b0;
  logic          rst_ni;
  logic          in_valid;
  logic          in_ready;
  logic [1:0]    item_mode;
  logic [IW-1:0] item_index;
  logic [VW-1:0] item_version;
  logic          out_valid;
  logic          out_ready;
  logic [IW:0]   res_index;
  logic [VW-1:0] res_version;
  logic          res_alive;
  logic [1:0]    res_status;
  bit            quiet = 1'b0;
  int unsigned   items_sent = 0;

  handle_table_sb sb = new();

  generational_handle_allocator_unit dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .mode_i           (item_mode),
    .slot_index_i     (item_index),
    .handle_version_i (item_version),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .out_index_o      (res_index),
    .out_version_o    (res_version),
    .alive_o          (res_alive),
    .status_o         (res_status)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid && out_ready)
      sb.check_result(res_index, res_version, res_alive, res_status);
  end

  initial begin
    out_ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (!quiet && $urandom_range(0, 9) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk_i);
      end
      out_ready <= 1'b1;
    end
  end

  task automatic pause_sender(int unsigned n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic send_item(logic [1:0] mode, logic [IW-1:0] idx, logic [VW-1:0] v);
    if (!quiet && $urandom_range(0, 7) == 0) pause_sender($urandom_range(1, 13));
    in_valid     <= 1'b1;
    item_mode    <= mode;
    item_index   <= idx;
    item_version <= v;
    do @(posedge clk_i); while (!in_ready);
    sb.note_input(mode, idx, v);
    items_sent++;
  endtask

  task automatic random_op(int unsigned p_create, int unsigned p_destroy, int unsigned p_query);
    int unsigned   roll;
    int unsigned   pick;
    int unsigned   idx;
    logic [VW-1:0] v;
    roll = $urandom_range(0, 99);
    pick = $urandom_range(0, 9);
    idx  = $urandom_range(0, SLOTS - 1);
    v    = VW'($urandom);
    if (roll < p_create) begin
      send_item(MODE_CREATE, IW'(idx), v);
    end else if (roll < p_create + p_destroy) begin
      if (pick < 8 && sb.pick_slot(1'b1, idx)) v = sb.ver_q[idx];
      else if (pick == 8 && sb.pick_slot(1'b1, idx))
        v = sb.ver_q[idx] ^ VW'($urandom_range(1, VMAX));
      else if (pick == 9 && sb.pick_slot(1'b0, idx)) v = sb.ver_q[idx] - 1'b1;
      else idx = $urandom_range(0, SLOTS - 1);
      send_item(MODE_DESTROY, IW'(idx), v);
    end else if (roll < p_create + p_destroy + p_query) begin
      if (pick < 6 && sb.pick_slot(1'b1, idx)) v = sb.ver_q[idx];
      else if (pick < 8 && sb.pick_slot(1'b0, idx)) v = sb.ver_q[idx] - VW'(pick - 6);
      else idx = $urandom_range(0, SLOTS - 1);
      send_item(MODE_QUERY, IW'(idx), v);
    end else begin
      if (pick < 7) idx = $urandom_range(0, sb.used - 1);
      send_item(MODE_FIND, IW'(idx), v);
    end
  endtask

  initial begin
    int unsigned k;
    rst_ni       <= 1'b0;
    in_valid     <= 1'b0;
    item_mode    <= MODE_CREATE;
    item_index   <= '0;
    item_version <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_item(MODE_QUERY, '0, '0);
    send_item(MODE_FIND, '0, '0);
    send_item(MODE_DESTROY, '0, '0);
    send_item(MODE_CREATE, '1, '1);
    send_item(MODE_CREATE, '0, '0);
    send_item(MODE_CREATE, '0, '0);
    send_item(MODE_QUERY, IW'(2), '0);
    send_item(MODE_QUERY, IW'(2), '1);
    send_item(MODE_QUERY, '1, '1);
    send_item(MODE_DESTROY, IW'(2), '0);
    send_item(MODE_DESTROY, IW'(2), VW'(1));
    send_item(MODE_QUERY, IW'(2), VW'(1));
    send_item(MODE_FIND, IW'(2), '0);
    send_item(MODE_FIND, '0, '1);
    send_item(MODE_DESTROY, IW'(3), '0);
    send_item(MODE_DESTROY, IW'(1), '0);
    send_item(MODE_FIND, '0, '0);
    send_item(MODE_CREATE, '0, '0);
    send_item(MODE_CREATE, '0, '0);
    send_item(MODE_CREATE, '0, '0);
    send_item(MODE_CREATE, '0, '0);
    send_item(MODE_FIND, '1, '0);
    send_item(MODE_QUERY, IW'(1), VW'(1));
    drain();

    for (k = 0; k < 300; k++) random_op(35, 30, 20);
    drain();

    k = 0;
    while (sb.n_full < 30 && k < 1500) begin
      random_op(88, 3, 5);
      k++;
    end
    drain();

    for (k = 0; k < 300; k++) begin
      if (k == 120) quiet = 1'b1;
      random_op(45, 40, 10);
    end
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("Sent %0d items: %0d creates, %0d destroys, %0d queries, %0d scans.",
             items_sent, sb.n_ops[MODE_CREATE], sb.n_ops[MODE_DESTROY],
             sb.n_ops[MODE_QUERY], sb.n_ops[MODE_FIND]);
    $display("Full-table rejects %0d, refused destroys %0d, scan hits %0d, checked %0d, bad %0d.",
             sb.n_full, sb.n_rejected, sb.n_found, sb.n_checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Timeout with %0d results outstanding", sb.pending());
    $display("Verification failed");
    $finish;
  end

endmodule
